>>> rtl/mck_pkg.sv
// Package for the Morse keyer: word types, opcodes, keyer phases and the
// character to dot/dash pattern lookup. No dependencies.
package mck_pkg;

  localparam int MSG_DEPTH = 32;
  localparam int MSG_AW    = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
  localparam int MSG_LW    = $clog2(MSG_DEPTH + 1);
  localparam int UNIT_W    = 16;
  localparam int CNT_W     = 19;
  localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd100;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_APPEND = 2'd1,
    OP_START  = 2'd2,
    OP_STOP   = 2'd3
  } mck_op_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_FETCH = 3'd1,
    PH_KEY   = 3'd2,
    PH_HOLD  = 3'd3,
    PH_GAP   = 3'd4
  } mck_phase_e;

  typedef enum logic [1:0] {
    CH_SKIP  = 2'd0,
    CH_KEYED = 2'd1,
    CH_SPACE = 2'd2
  } mck_kind_e;

  typedef struct packed {
    mck_op_e    opcode;
    logic [7:0] char_code;
  } mck_in_t;

  typedef struct packed {
    logic led_on;
    logic sending;
    logic overflow;
  } mck_out_t;

  typedef struct packed {
    mck_kind_e  kind;
    logic [2:0] elements;
    logic [4:0] pattern;
  } mck_sym_t;

  // {element count, pattern}, first element in the highest used bit, 1 dash
  localparam logic [7:0] LETTER_TAB [26] = '{
    {3'd2, 5'h01}, {3'd4, 5'h08}, {3'd4, 5'h0A}, {3'd3, 5'h04}, {3'd1, 5'h00},
    {3'd4, 5'h02}, {3'd3, 5'h06}, {3'd4, 5'h00}, {3'd2, 5'h00}, {3'd4, 5'h07},
    {3'd3, 5'h05}, {3'd4, 5'h04}, {3'd2, 5'h03}, {3'd2, 5'h02}, {3'd3, 5'h07},
    {3'd4, 5'h06}, {3'd4, 5'h0D}, {3'd3, 5'h02}, {3'd3, 5'h00}, {3'd1, 5'h01},
    {3'd3, 5'h01}, {3'd4, 5'h01}, {3'd3, 5'h03}, {3'd4, 5'h09}, {3'd4, 5'h0B},
    {3'd4, 5'h0C}
  };

  localparam logic [4:0] DIGIT_TAB [10] = '{
    5'h1F, 5'h0F, 5'h07, 5'h03, 5'h01, 5'h00, 5'h10, 5'h18, 5'h1C, 5'h1E
  };

  function automatic mck_sym_t mck_decode(input logic [7:0] ch);
    logic [7:0] up;
    logic [7:0] li;
    logic [7:0] di;
    mck_sym_t   s;
    up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
    li = up - 8'h41;
    di = up - 8'h30;
    s.kind     = CH_SKIP;
    s.elements = 3'd0;
    s.pattern  = 5'd0;
    if (up >= 8'h41 && up <= 8'h5A) begin
      s.kind     = CH_KEYED;
      s.elements = LETTER_TAB[li[4:0]][7:5];
      s.pattern  = LETTER_TAB[li[4:0]][4:0];
    end else if (up >= 8'h30 && up <= 8'h39) begin
      s.kind     = CH_KEYED;
      s.elements = 3'd5;
      s.pattern  = DIGIT_TAB[di[3:0]];
    end else if (up == 8'h20) begin
      s.kind = CH_SPACE;
    end
    return s;
  endfunction

endpackage

>>> rtl/mck_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mck_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/morse_code_led_keyer.sv
// Morse keyer top level: message store in mck_ram, keyer sequencer, output word
// register and unit length register. Depends on mck_pkg and mck_ram.
//
//   channel | direction | word        | handshake
//   in_     | in        | mck_in_t    | in_valid / in_ready
//   out_    | out       | mck_out_t   | out_valid / out_ready
//   cfg_    | in        | 16-bit unit | cfg_valid / cfg_ready (always ready)
//
// A tick that fetches a character reads the store, whose read data is
// registered; no new word is taken until that character is decoded.
// The result word sits in a register; a new word is taken while it waits
// only if out_ready frees the slot in the same cycle.
// Synchronous active-low reset; no clearing pass, the store needs none.
module morse_code_led_keyer
  import mck_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mck_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mck_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [UNIT_W-1:0]   cfg_data
);

  logic [UNIT_W-1:0] unit_r;
  logic [MSG_LW-1:0] len_r, len_nxt;
  logic [MSG_LW-1:0] ridx_r, ridx_nxt;
  mck_phase_e        phase_r, phase_nxt;
  logic [2:0]        el_r, el_nxt;
  logic [4:0]        pat_r, pat_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              led_r, led_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r;
  mck_out_t          out_r, out_nxt;

  logic              in_fire;
  logic              ram_we, ram_re;
  logic [MSG_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [MSG_LW-1:0] fidx;
  logic              cnt_done;
  logic [2:0]        el_m1;
  mck_sym_t          sym;
  logic [CNT_W-1:0]  unit1, unit3, unit7;

  assign cfg_ready = 1'b1;
  assign in_ready  = !pend_r && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign unit1    = CNT_W'(unit_r);
  assign unit3    = CNT_W'({unit_r, 1'b0}) + unit1;
  assign unit7    = CNT_W'({unit_r, 3'b000}) - unit1;
  assign cnt_done = (cnt_r <= CNT_W'(1));
  assign el_m1    = el_r - 3'd1;
  assign fidx     = (ridx_r >= len_r) ? '0 : ridx_r;
  assign sym      = mck_decode(ram_rdata);

  mck_ram #(
    .WIDTH (8),
    .DEPTH (MSG_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[MSG_AW-1:0]),
    .wdata (in_data.char_code),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    len_nxt   = len_r;
    ridx_nxt  = ridx_r;
    phase_nxt = phase_r;
    el_nxt    = el_r;
    pat_nxt   = pat_r;
    cnt_nxt   = cnt_r;
    led_nxt   = led_r;
    pend_nxt  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = fidx[MSG_AW-1:0];
    out_nxt   = out_r;
    if (pend_r) begin
      unique case (sym.kind)
        CH_KEYED: begin
          el_nxt    = sym.elements;
          pat_nxt   = sym.pattern;
          phase_nxt = PH_KEY;
        end
        CH_SPACE: begin
          cnt_nxt   = unit7;
          phase_nxt = PH_GAP;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      out_nxt.overflow = 1'b0;
      unique case (in_data.opcode)
        OP_TICK: begin
          unique case (phase_r)
            PH_FETCH: begin
              if (len_r != '0) begin
                ram_re   = 1'b1;
                ridx_nxt = fidx + MSG_LW'(1);
                pend_nxt = 1'b1;
              end
            end
            PH_KEY: begin
              if (el_r == 3'd0) begin
                phase_nxt = PH_FETCH;
              end else begin
                el_nxt    = el_m1;
                led_nxt   = 1'b1;
                cnt_nxt   = pat_r[el_m1] ? unit3 : unit1;
                phase_nxt = PH_HOLD;
              end
            end
            PH_HOLD: begin
              if (cnt_done) begin
                led_nxt   = 1'b0;
                cnt_nxt   = (el_r != 3'd0) ? unit1 : unit3;
                phase_nxt = PH_GAP;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            PH_GAP: begin
              if (cnt_done) begin
                cnt_nxt   = '0;
                phase_nxt = (el_r != 3'd0) ? PH_KEY : PH_FETCH;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
        OP_APPEND: begin
          if (len_r < MSG_LW'(MSG_DEPTH)) begin
            ram_we  = 1'b1;
            len_nxt = len_r + MSG_LW'(1);
          end else begin
            out_nxt.overflow = 1'b1;
          end
        end
        OP_START: begin
          if (phase_r == PH_IDLE) begin
            ridx_nxt  = '0;
            el_nxt    = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_FETCH;
          end
        end
        OP_STOP: begin
          led_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
        end
      endcase
      out_nxt.led_on  = led_nxt;
      out_nxt.sending = (phase_nxt != PH_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r      <= UNIT_RESET;
      len_r       <= '0;
      ridx_r      <= '0;
      phase_r     <= PH_IDLE;
      el_r        <= '0;
      pat_r       <= '0;
      cnt_r       <= '0;
      led_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unit_r <= cfg_data;
      end
      len_r   <= len_nxt;
      ridx_r  <= ridx_nxt;
      phase_r <= phase_nxt;
      el_r    <= el_nxt;
      pat_r   <= pat_nxt;
      cnt_r   <= cnt_nxt;
      led_r   <= led_nxt;
      pend_r  <= pend_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> rtl/mck_checker.sv
// Port-level checks for the Morse keyer, bound to morse_code_led_keyer.
// Depends on mck_pkg.
module mck_checker
  import mck_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input mck_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input mck_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  a_ovf_append: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode != OP_APPEND |=> !out_data.overflow)
    else $error("overflow flagged on a word that is no append");

  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode == OP_STOP
      |=> !out_data.led_on && !out_data.sending)
    else $error("stop left the LED lit or the keyer running");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.opcode == OP_START |=> out_data.sending)
    else $error("start did not leave the keyer sending");

endmodule

bind morse_code_led_keyer mck_checker u_mck_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
